@@ rtl/otsu_pkg.sv @@
// Package for the histogram threshold binariser: field widths, request codes,
// output levels and default sizes. It depends on nothing else.
package otsu_pkg;

    localparam int BIN_COUNT_DEF  = 64;
    localparam int COUNT_BITS_DEF = 22;

    localparam int ACTION_BITS = 2;
    localparam int PIXEL_BITS  = 8;
    localparam int SPLIT_BITS  = 6;

    // Request codes carried on the action field.
    localparam logic [ACTION_BITS-1:0] ACT_ADD      = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_COMPUTE  = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_CLASSIFY = 2'd2;

    localparam logic [PIXEL_BITS-1:0] PIXEL_BLACK = 8'd0;
    localparam logic [PIXEL_BITS-1:0] PIXEL_WHITE = 8'd255;

endpackage

@@ rtl/otsu_threshold_binarize.sv @@
// Top level of the histogram threshold binariser: histogram memory, split search
// driven by one shared shift-and-add multiplier, and pixel classification.
// Depends on otsu_pkg.
//
// Usage: requests arrive on in_valid/in_ready with an action and a pixel value.
// An add request counts the pixel into bin pixel/4 (saturating) and gives no
// result. A classify request gives one result of 0 or 255 against the stored
// split index times four. A compute request walks the histogram twice: one pass
// that reads each bin to form the totals, then one pass over every split where
// the six products of the exact variance compare run on a single bit-serial
// multiplier, one multiplier bit per cycle. It then gives the split index, stores
// it and empties the histogram together, once the output register is free.
// Results leave through an output register on out_valid/out_ready; adds are
// still taken while a result waits, and a classify request waits until the
// output register is free. Reset empties the histogram and sets the stored
// split index to zero.
module otsu_threshold_binarize #(
    parameter int BIN_COUNT  = otsu_pkg::BIN_COUNT_DEF,
    parameter int COUNT_BITS = otsu_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [otsu_pkg::ACTION_BITS-1:0]  action,
    input  logic [otsu_pkg::PIXEL_BITS-1:0]   pixel_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              is_threshold,
    output logic [otsu_pkg::SPLIT_BITS-1:0]   threshold_index,
    output logic [otsu_pkg::PIXEL_BITS-1:0]   binary_pixel
);
    import otsu_pkg::*;

    localparam int IDX_BITS = $clog2(BIN_COUNT);
    localparam int N_BITS   = COUNT_BITS + IDX_BITS;
    localparam int S_BITS   = N_BITS + IDX_BITS;
    localparam int P_BITS   = S_BITS + N_BITS;
    localparam int NUM_BITS = 2 * P_BITS;
    localparam int DEN_BITS = 2 * N_BITS;
    localparam int CMP_BITS = NUM_BITS + DEN_BITS;
    localparam int LAST_BIN = BIN_COUNT - 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_WR,
        S_SUM_RD,
        S_SUM_ACC,
        S_SC_CHK,
        S_MUL,
        S_SC_UPD,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PH_C,
        PH_D,
        PH_NUM,
        PH_DEN,
        PH_LHS,
        PH_RHS
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    logic [COUNT_BITS-1:0] bin_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]  valid_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic [IDX_BITS-1:0]   rd_addr;
    logic [IDX_BITS-1:0]   wr_addr_reg;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] wr_data;

    logic [IDX_BITS-1:0]   idx_reg;
    logic [N_BITS-1:0]     n1_reg;
    logic [N_BITS-1:0]     n2_reg;
    logic [S_BITS-1:0]     s1_reg;
    logic [S_BITS-1:0]     s2_reg;
    logic [P_BITS-1:0]     c_reg;
    logic [NUM_BITS-1:0]   num_reg;
    logic [DEN_BITS-1:0]   den_reg;
    logic [CMP_BITS-1:0]   lhs_reg;
    logic [NUM_BITS-1:0]   best_num_reg;
    logic [DEN_BITS-1:0]   best_den_reg;
    logic [IDX_BITS-1:0]   best_idx_reg;

    logic [CMP_BITS-1:0]   acc_reg;
    logic [CMP_BITS-1:0]   mcand_reg;
    logic [P_BITS-1:0]     mplier_reg;

    logic [SPLIT_BITS-1:0] split_reg;
    logic                  out_valid_reg;
    logic                  is_threshold_reg;
    logic [SPLIT_BITS-1:0] threshold_index_reg;
    logic [PIXEL_BITS-1:0] binary_pixel_reg;

    logic [8:0]                   in_bin_wide;
    logic [IDX_BITS-1:0]          in_bin;
    logic                         out_free;
    logic                         accept;
    logic [COUNT_BITS-1:0]        cnt_now;
    logic [N_BITS-1:0]            cnt_x_idx;
    logic [P_BITS-1:0]            d_val;
    logic [P_BITS-1:0]            diff;
    logic                         last_idx;

    // Bins past the end of a short histogram fold into the last bin.
    always_comb
    begin
        if (int'(pixel_value[7:2]) > LAST_BIN)
        begin
            in_bin_wide = 9'(LAST_BIN);
        end
        else
        begin
            in_bin_wide = {3'b000, pixel_value[7:2]};
        end
    end

    assign in_bin    = IDX_BITS'(in_bin_wide);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && ((action != ACT_CLASSIFY) || out_free);
    assign accept    = in_valid && in_ready;
    assign rd_addr   = (state_reg == S_IDLE) ? in_bin : idx_reg;
    assign cnt_now   = rd_valid_reg ? rd_data_reg : '0;
    assign cnt_x_idx = N_BITS'(cnt_now) * N_BITS'(idx_reg);
    assign wr_en     = (state_reg == S_ADD_WR) && (cnt_now != '1);
    assign wr_data   = cnt_now + COUNT_BITS'(1);
    assign d_val     = acc_reg[P_BITS-1:0];
    assign diff      = (c_reg >= d_val) ? (c_reg - d_val) : (d_val - c_reg);
    assign last_idx  = (idx_reg == IDX_BITS'(LAST_BIN));

    assign out_valid       = out_valid_reg;
    assign is_threshold    = is_threshold_reg;
    assign threshold_index = threshold_index_reg;
    assign binary_pixel    = binary_pixel_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[wr_addr_reg] <= wr_data;
        end
        rd_data_reg <= bin_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            phase_reg           <= PH_C;
            valid_reg           <= '0;
            rd_valid_reg        <= 1'b0;
            wr_addr_reg         <= '0;
            idx_reg             <= '0;
            n1_reg              <= '0;
            n2_reg              <= '0;
            s1_reg              <= '0;
            s2_reg              <= '0;
            c_reg               <= '0;
            num_reg             <= '0;
            den_reg             <= '0;
            lhs_reg             <= '0;
            best_num_reg        <= '0;
            best_den_reg        <= '0;
            best_idx_reg        <= '0;
            acc_reg             <= '0;
            mcand_reg           <= '0;
            mplier_reg          <= '0;
            split_reg           <= '0;
            out_valid_reg       <= 1'b0;
            is_threshold_reg    <= 1'b0;
            threshold_index_reg <= '0;
            binary_pixel_reg    <= '0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (wr_en)
            begin
                valid_reg[wr_addr_reg] <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (action)
                            ACT_ADD:
                            begin
                                wr_addr_reg <= in_bin;
                                state_reg   <= S_ADD_WR;
                            end
                            ACT_COMPUTE:
                            begin
                                idx_reg      <= '0;
                                n1_reg       <= '0;
                                n2_reg       <= '0;
                                s1_reg       <= '0;
                                s2_reg       <= '0;
                                best_num_reg <= '0;
                                best_den_reg <= DEN_BITS'(1);
                                best_idx_reg <= '0;
                                state_reg    <= S_SUM_RD;
                            end
                            ACT_CLASSIFY:
                            begin
                                out_valid_reg       <= 1'b1;
                                is_threshold_reg    <= 1'b0;
                                threshold_index_reg <= split_reg;
                                binary_pixel_reg    <= (pixel_value < {split_reg, 2'b00})
                                                       ? PIXEL_BLACK : PIXEL_WHITE;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_ADD_WR:
                begin
                    state_reg <= S_IDLE;
                end

                S_SUM_RD:
                begin
                    state_reg <= S_SUM_ACC;
                end

                S_SUM_ACC:
                begin
                    n2_reg <= n2_reg + N_BITS'(cnt_now);
                    s2_reg <= s2_reg + S_BITS'(cnt_x_idx);
                    if (last_idx)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SC_CHK;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_BITS'(1);
                        state_reg <= S_SUM_RD;
                    end
                end

                // The bin count for this split is read here and used in S_SC_UPD.
                S_SC_CHK:
                begin
                    if ((n1_reg != '0) && (n2_reg != '0))
                    begin
                        acc_reg    <= '0;
                        mcand_reg  <= CMP_BITS'(s1_reg);
                        mplier_reg <= P_BITS'(n2_reg);
                        phase_reg  <= PH_C;
                        state_reg  <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_SC_UPD;
                    end
                end

                // One multiplier bit per cycle; a product is complete once no
                // set bit remains in the multiplier.
                S_MUL:
                begin
                    if (mplier_reg != '0)
                    begin
                        if (mplier_reg[0])
                        begin
                            acc_reg <= acc_reg + mcand_reg;
                        end
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                    end
                    else
                    begin
                        acc_reg <= '0;
                        case (phase_reg)
                            PH_C:
                            begin
                                c_reg      <= acc_reg[P_BITS-1:0];
                                mcand_reg  <= CMP_BITS'(s2_reg);
                                mplier_reg <= P_BITS'(n1_reg);
                                phase_reg  <= PH_D;
                            end
                            PH_D:
                            begin
                                mcand_reg  <= CMP_BITS'(diff);
                                mplier_reg <= diff;
                                phase_reg  <= PH_NUM;
                            end
                            PH_NUM:
                            begin
                                num_reg    <= acc_reg[NUM_BITS-1:0];
                                mcand_reg  <= CMP_BITS'(n1_reg);
                                mplier_reg <= P_BITS'(n2_reg);
                                phase_reg  <= PH_DEN;
                            end
                            PH_DEN:
                            begin
                                den_reg    <= acc_reg[DEN_BITS-1:0];
                                mcand_reg  <= CMP_BITS'(num_reg);
                                mplier_reg <= P_BITS'(best_den_reg);
                                phase_reg  <= PH_LHS;
                            end
                            PH_LHS:
                            begin
                                lhs_reg    <= acc_reg;
                                mcand_reg  <= CMP_BITS'(best_num_reg);
                                mplier_reg <= P_BITS'(den_reg);
                                phase_reg  <= PH_RHS;
                            end
                            PH_RHS:
                            begin
                                // Only a strictly larger variance replaces the best.
                                if (lhs_reg > acc_reg)
                                begin
                                    best_num_reg <= num_reg;
                                    best_den_reg <= den_reg;
                                    best_idx_reg <= idx_reg;
                                end
                                state_reg <= S_SC_UPD;
                            end
                            default:
                            begin
                                state_reg <= S_SC_UPD;
                            end
                        endcase
                    end
                end

                S_SC_UPD:
                begin
                    n1_reg <= n1_reg + N_BITS'(cnt_now);
                    n2_reg <= n2_reg - N_BITS'(cnt_now);
                    s1_reg <= s1_reg + S_BITS'(cnt_x_idx);
                    s2_reg <= s2_reg - S_BITS'(cnt_x_idx);
                    if (last_idx)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_BITS'(1);
                        state_reg <= S_SC_CHK;
                    end
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        split_reg           <= SPLIT_BITS'(best_idx_reg);
                        valid_reg           <= '0;
                        out_valid_reg       <= 1'b1;
                        is_threshold_reg    <= 1'b1;
                        threshold_index_reg <= SPLIT_BITS'(best_idx_reg);
                        binary_pixel_reg    <= PIXEL_BLACK;
                        state_reg           <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for otsu_threshold_binarize: directed and random requests
// checked against a cycle-free histogram and split-search predictor held here.
// Depends on otsu_pkg and the otsu_threshold_binarize RTL.
module tb_top;
    import otsu_pkg::*;

    localparam int                     BINS         = BIN_COUNT_DEF;
    localparam int                     CNT_BITS     = COUNT_BITS_DEF;
    localparam logic [ACTION_BITS-1:0] ACT_UNUSED   = 2'd3;
    localparam int                     HOLD_CYCLES  = 300;
    localparam int                     WATCHDOG_MAX = 100000;
    localparam int                     DRAIN_CYCLES = 40;

    typedef struct packed {
        logic                  is_thr;
        logic [SPLIT_BITS-1:0] index;
        logic [PIXEL_BITS-1:0] level;
    } otsu_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [ACTION_BITS-1:0] action = ACT_ADD;
    logic [PIXEL_BITS-1:0]  pixel_value = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   is_threshold;
    logic [SPLIT_BITS-1:0]  threshold_index;
    logic [PIXEL_BITS-1:0]  binary_pixel;

    // Predictor state: the histogram and the stored split index.
    logic [CNT_BITS-1:0]    hist_model [BINS];
    logic [SPLIT_BITS-1:0]  split_model = '0;
    otsu_result_t           pending_results [$];

    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     requests_sent = 0;
    int                     error_count = 0;
    int                     quiet_cycles = 0;
    logic                   hold_request = 1'b0;
    logic                   hold_seen = 1'b0;
    int                     hold_left = 0;

    otsu_threshold_binarize dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .pixel_value     (pixel_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .is_threshold    (is_threshold),
        .threshold_index (threshold_index),
        .binary_pixel    (binary_pixel)
    );

    always #5 clk = ~clk;

    // Exact between-class variance search; the first strictly largest split wins.
    function automatic logic [SPLIT_BITS-1:0] find_best_split();
        bit [255:0] n1, n2, s1, s2, c, d, diff, num, den, lhs, rhs;
        bit [255:0] best_num, best_den;
        int         best;
        n1 = '0;
        n2 = '0;
        s1 = '0;
        s2 = '0;
        best = 0;
        best_num = '0;
        best_den = 256'(1);
        for (int i = 0; i < BINS; i++)
        begin
            n2 += 256'(hist_model[i]);
            s2 += 256'(hist_model[i]) * 256'(i);
        end
        for (int i = 0; i < BINS; i++)
        begin
            if (n1 != 0 && n2 != 0)
            begin
                c = s1 * n2;
                d = s2 * n1;
                diff = (c >= d) ? c - d : d - c;
                num = diff * diff;
                den = n1 * n2;
                lhs = num * best_den;
                rhs = best_num * den;
                if (lhs > rhs)
                begin
                    best_num = num;
                    best_den = den;
                    best = i;
                end
            end
            n1 += 256'(hist_model[i]);
            n2 -= 256'(hist_model[i]);
            s1 += 256'(hist_model[i]) * 256'(i);
            s2 -= 256'(hist_model[i]) * 256'(i);
        end
        return best[SPLIT_BITS-1:0];
    endfunction

    function automatic void predict_request(input logic [ACTION_BITS-1:0] act,
                                            input logic [PIXEL_BITS-1:0] px);
        int bin;
        bin = int'(px >> 2);
        if (bin > BINS - 1)
            bin = BINS - 1;
        case (act)
            ACT_ADD:
            begin
                if (hist_model[bin] != {CNT_BITS{1'b1}})
                    hist_model[bin] = hist_model[bin] + CNT_BITS'(1);
            end
            ACT_COMPUTE:
            begin
                split_model = find_best_split();
                pending_results.push_back('{1'b1, split_model, PIXEL_BLACK});
                for (int i = 0; i < BINS; i++)
                    hist_model[i] = '0;
            end
            ACT_CLASSIFY:
                pending_results.push_back('{1'b0, split_model,
                    (px < {split_model, 2'b00}) ? PIXEL_BLACK : PIXEL_WHITE});
            default:
            begin
            end
        endcase
    endfunction

    // Offers one request, possibly after a random gap, and returns once it is taken.
    // Valid is only lowered when a gap is inserted, never in the step that raises it.
    task automatic send_request(input logic [ACTION_BITS-1:0] act,
                                input logic [PIXEL_BITS-1:0] px);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        pixel_value <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(act, px);
        if (act != ACT_UNUSED)
            requests_sent++;
    endtask

    // One image: pixels from a chosen distribution, a compute, then classify requests.
    // Now and then a stray request is mixed in or the compute is left out.
    task automatic send_frame(input int n_pixels, input int n_classify);
        int shape, c0, c1, w0, w1, v;
        shape = $urandom_range(3);
        c0 = $urandom_range(255);
        c1 = $urandom_range(255);
        w0 = $urandom_range(1, 40);
        w1 = $urandom_range(1, 40);
        for (int k = 0; k < n_pixels; k++)
        begin
            if ($urandom_range(99) < 4)
                send_request(ACTION_BITS'($urandom_range(3)), PIXEL_BITS'($urandom));
            case (shape)
                0: v = $urandom_range(255);
                1:
                begin
                    if ($urandom_range(1) == 0)
                        v = c0 + $urandom_range(2 * w0) - w0;
                    else
                        v = c1 + $urandom_range(2 * w1) - w1;
                end
                2: v = c0;
                default: v = ($urandom_range(3) == 0) ? $urandom_range(255)
                                                      : 255 * $urandom_range(1);
            endcase
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            send_request(ACT_ADD, PIXEL_BITS'(v));
        end
        if ($urandom_range(99) < 92)
            send_request(ACT_COMPUTE, PIXEL_BITS'($urandom));
        for (int k = 0; k < n_classify; k++)
        begin
            if ($urandom_range(99) < 5)
                send_request(ACT_UNUSED, PIXEL_BITS'($urandom));
            send_request(ACT_CLASSIFY, PIXEL_BITS'($urandom));
        end
    endtask

    task automatic test_split_search_cases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // Stored index is zero after reset, so every pixel classifies white.
        send_request(ACT_CLASSIFY, 8'd0);
        send_request(ACT_CLASSIFY, 8'd255);
        // Empty histogram: no split is better than none.
        send_request(ACT_COMPUTE, 8'd0);
        // Two extreme pixels: every split between them ties, so the first one wins.
        send_request(ACT_ADD, 8'd0);
        send_request(ACT_ADD, 8'd255);
        send_request(ACT_COMPUTE, 8'd255);
        send_request(ACT_CLASSIFY, 8'd3);
        send_request(ACT_CLASSIFY, 8'd4);
        send_request(ACT_CLASSIFY, 8'd255);
        // The unused code must leave the histogram alone and give nothing.
        send_request(ACT_UNUSED, 8'd255);
        // One populated bin: one class is always empty, so the index falls back to zero.
        send_request(ACT_ADD, 8'd128);
        send_request(ACT_ADD, 8'd129);
        send_request(ACT_ADD, 8'd131);
        send_request(ACT_COMPUTE, 8'd0);
        send_request(ACT_CLASSIFY, 8'd0);
        send_request(ACT_ADD, 8'd7);
        send_request(ACT_ADD, 8'd8);
        send_request(ACT_ADD, 8'd200);
        send_request(ACT_ADD, 8'd252);
        send_request(ACT_COMPUTE, 8'd0);
        send_request(ACT_CLASSIFY, 8'd100);
        send_request(ACT_CLASSIFY, 8'd170);
        send_request(ACT_CLASSIFY, 8'd255);
    endtask

    task automatic test_random_frames();
        int target;
        int send_pct [4] = '{0, 66, 0, 34};
        int recv_pct [4] = '{0, 0, 66, 34};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            target = requests_sent + 440;
            while (requests_sent < target)
            begin
                if ($urandom_range(99) < 4)
                    send_frame($urandom_range(100, 250), $urandom_range(1, 6));
                else
                    send_frame($urandom_range(0, 40), $urandom_range(1, 12));
            end
        end
    endtask

    // The receiver stops for a long stretch while classify requests keep coming,
    // so the output register fills and the input has to stall.
    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request <= ~hold_request;
        for (int k = 0; k < 24; k++)
            send_request((k % 3 == 0) ? ACT_ADD : ACT_CLASSIFY, PIXEL_BITS'($urandom));
        send_request(ACT_COMPUTE, 8'd0);
        send_request(ACT_CLASSIFY, PIXEL_BITS'($urandom));
    endtask

    always @(posedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        otsu_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: is_threshold %0d threshold_index %0d binary_pixel %0d",
                       is_threshold, threshold_index, binary_pixel);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (is_threshold !== exp_res.is_thr)
                begin
                    $error("is_threshold: expected %0d, got %0d", exp_res.is_thr, is_threshold);
                    error_count++;
                end
                if (threshold_index !== exp_res.index)
                begin
                    $error("threshold_index: expected %0d, got %0d",
                           exp_res.index, threshold_index);
                    error_count++;
                end
                if (binary_pixel !== exp_res.level)
                begin
                    $error("binary_pixel: expected %0d, got %0d", exp_res.level, binary_pixel);
                    error_count++;
                end
            end
        end
    end

    // A compute walks the whole histogram with nothing accepted, hence the wide margin.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < BINS; i++)
            hist_model[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_split_search_cases();
        test_random_frames();
        test_output_hold_off();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
